// File: rtl/flc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_pkg: shared types and constants for the lookup cache
// Request and response payloads, request kinds and the controller command.
// ----------------------------------------------------------------------------
package flc_pkg;

   localparam int CACHE_ENTRIES_DEFAULT = 8;

   localparam int CODE_W   = 31;
   localparam int PRICE_W  = 32;
   localparam int VISITS_W = 16;
   localparam int SLOT_W   = 3;

   localparam logic [VISITS_W-1:0] VISIT_MAX = {VISITS_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_FILL   = 2'd1,
      KIND_UPDATE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [CODE_W-1:0]  item_code;
      logic [PRICE_W-1:0] price_in;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic [PRICE_W-1:0]  price_out;
      logic [VISITS_W-1:0] visit_count;
      logic                evicted;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic match_en;
      logic write_en;
   } cmd_type;

endpackage

// File: rtl/flc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_ctrl: request sequencer
// Steps each request through a match state and a write state and owns the
// handshakes of the request and response channels.
// ----------------------------------------------------------------------------
module flc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output flc_pkg::cmd_type cmd
);
   import flc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MATCH = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The response register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.match_en = 1'b0;
      cmd.write_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match_en = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               cmd.write_en = 1'b1;
               req_ready    = 1'b1;
               state_in     = req_valid ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.load_req = req_valid && req_ready;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/flc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flc_datapath: entry storage, match logic and response register
// Holds the entries oldest first, compares all valid slots in parallel and
// applies lookup, fill and price update writes.
// ----------------------------------------------------------------------------
module flc_datapath #(
   parameter int ENTRIES = flc_pkg::CACHE_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  flc_pkg::cmd_type cmd,
   input  flc_pkg::req_type req_data,
   input  logic             csr_write,
   input  logic             csr_data,
   output flc_pkg::rsp_type rsp_data
);
   import flc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   req_type             req_ff;
   logic                enable_ff;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   rsp_type             rsp_ff, rsp_in;

   logic [CODE_W-1:0]   code_ff   [ENTRIES];
   logic [CODE_W-1:0]   code_in   [ENTRIES];
   logic [PRICE_W-1:0]  price_ff  [ENTRIES];
   logic [PRICE_W-1:0]  price_in  [ENTRIES];
   logic [VISITS_W-1:0] visits_ff [ENTRIES];
   logic [VISITS_W-1:0] visits_in [ENTRIES];

   logic [ENTRIES-1:0]  match;
   logic                full;
   logic [IDX_W-1:0]    fill_pos;
   logic                do_lookup_hit, do_fill, do_update;
   logic [VISITS_W-1:0] cur_visits, inc_visits;

   // Match stage: compare every valid slot, lowest slot wins.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (CNT_W'(i) < fill_ff) && (code_ff[i] == req_ff.item_code);
      end
      idx_in = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            idx_in = IDX_W'(i);
         end
      end
      hit_in = |match;
   end

   // Write stage decode.
   assign full          = (fill_ff == CNT_W'(ENTRIES));
   assign fill_pos      = full ? LAST_IDX : fill_ff[IDX_W-1:0];
   assign do_lookup_hit = cmd.write_en && (req_ff.kind == KIND_LOOKUP) && enable_ff && hit_ff;
   assign do_fill       = cmd.write_en && (req_ff.kind == KIND_FILL);
   assign do_update     = cmd.write_en && (req_ff.kind == KIND_UPDATE) && hit_ff;
   assign cur_visits    = visits_ff[idx_ff];
   assign inc_visits    = (cur_visits == VISIT_MAX) ? cur_visits : cur_visits + 1'b1;

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_slot
         logic [CODE_W-1:0]   shift_code;
         logic [PRICE_W-1:0]  shift_price;
         logic [VISITS_W-1:0] shift_visits;

         // On a full fill every slot takes its younger neighbor; the last
         // slot takes the new entry.
         if (g < ENTRIES - 1) begin : g_mid
            assign shift_code   = code_ff[g+1];
            assign shift_price  = price_ff[g+1];
            assign shift_visits = visits_ff[g+1];
         end else begin : g_last
            assign shift_code   = req_ff.item_code;
            assign shift_price  = req_ff.price_in;
            assign shift_visits = VISITS_W'(1);
         end

         always_comb begin
            code_in[g]   = code_ff[g];
            price_in[g]  = price_ff[g];
            visits_in[g] = visits_ff[g];
            if (do_fill && full) begin
               code_in[g]   = shift_code;
               price_in[g]  = shift_price;
               visits_in[g] = shift_visits;
            end else if (do_fill && (fill_pos == IDX_W'(g))) begin
               code_in[g]   = req_ff.item_code;
               price_in[g]  = req_ff.price_in;
               visits_in[g] = VISITS_W'(1);
            end
            if (do_lookup_hit && (idx_ff == IDX_W'(g))) begin
               visits_in[g] = inc_visits;
            end
            if (do_update && (idx_ff == IDX_W'(g))) begin
               price_in[g] = req_ff.price_in;
            end
         end

         always_ff @(posedge clock) begin
            code_ff[g]   <= code_in[g];
            price_ff[g]  <= price_in[g];
            visits_ff[g] <= visits_in[g];
         end
      end
   endgenerate

   always_comb begin
      fill_in = fill_ff;
      if (do_fill && !full) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in = '0;
      case (req_ff.kind)
         KIND_LOOKUP: begin
            if (enable_ff && hit_ff) begin
               rsp_in.hit         = 1'b1;
               rsp_in.slot        = SLOT_W'(idx_ff);
               rsp_in.price_out   = price_ff[idx_ff];
               rsp_in.visit_count = inc_visits;
            end
         end
         KIND_FILL: begin
            rsp_in.slot        = SLOT_W'(fill_pos);
            rsp_in.visit_count = VISITS_W'(1);
            rsp_in.evicted     = full;
         end
         KIND_UPDATE: begin
            if (hit_ff) begin
               rsp_in.hit         = 1'b1;
               rsp_in.slot        = SLOT_W'(idx_ff);
               rsp_in.visit_count = cur_visits;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         enable_ff <= 1'b1;
      end else begin
         fill_ff <= fill_in;
         if (csr_write) begin
            enable_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.match_en) begin
         hit_ff <= hit_in;
         idx_ff <= idx_in;
      end
      if (cmd.write_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/fifo_lookup_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_lookup_cache_core: fully associative price cache, oldest-out refill
// Top level joining the request sequencer and the entry datapath.
// ----------------------------------------------------------------------------
// Usage:
// A request (lookup, fill or price update) is a transfer on the req_ channel.
// Each request yields exactly one response transfer on the rsp_ channel, in
// request order. A request passes through the parallel match stage and then
// the write stage, which loads the response register. The next request is
// accepted while the previous one is in the write stage, never while it is
// in the match stage, so the match stage sees the entries written by the
// previous request. The entries live in flip-flops.
// The response sits in an output register; the next request is accepted and
// matched while it waits. If the receiver stalls, the write stage holds
// until the register frees up, and req_ready stays low meanwhile.
// The csr_ channel writes cache_enable (always ready); write it only while
// no request is in flight. Reset empties the cache and sets cache_enable.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fifo_lookup_cache_core #(
   parameter int CACHE_ENTRIES = flc_pkg::CACHE_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  flc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output flc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);
   import flc_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   flc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   flc_datapath #(
      .ENTRIES (CACHE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule
